// File: rtl/asha_pkg.sv
package asha_pkg;

  localparam int unsigned DefMaxSegments = 64;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [1:0] POL_FIRST   = 2'd0;
  localparam logic [1:0] POL_CLOSEST = 2'd1;
  localparam logic [1:0] POL_LAST    = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOFIT    = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [1:0] CFG_BASE   = 2'd0;
  localparam logic [1:0] CFG_BYTES  = 2'd1;
  localparam logic [1:0] CFG_POLICY = 2'd2;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
    logic        used;
    logic [31:0] client;
  } seg_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_rd;
    logic stat_rd;
    logic wr_init;
    logic wr_shift;
    logic wr_e1;
    logic wr_e2;
    logic decide;
    logic commit;
    logic load_out;
  } asha_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic init_pend;
    logic modify;
    logic sh_en;
    logic sh_up;
    logic two_wr;
    logic out_free;
  } asha_sts_t;

endpackage

// File: rtl/asha_if.sv
interface asha_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [31:0] request_bytes;
  logic [3:0]  align_log2;
  logic [31:0] free_address;

  modport source (output valid, op, request_bytes, align_log2, free_address, input ready);
  modport sink   (input valid, op, request_bytes, align_log2, free_address, output ready);
endinterface

interface asha_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status_code;
  logic [31:0] client_address;
  logic [31:0] total_free;
  logic [31:0] largest_free;
  logic [6:0]  used_count;

  modport source (output valid, status_code, client_address, total_free, largest_free,
                  used_count, input ready);
  modport sink   (input valid, status_code, client_address, total_free, largest_free,
                  used_count, output ready);
endinterface

// File: rtl/asha_ram.sv
module asha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/asha_ctrl.sv
module asha_ctrl #(
  parameter int unsigned MAX_SEGMENTS = asha_pkg::DefMaxSegments
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  asha_pkg::asha_sts_t             sts_i,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] last_idx_i,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] sh_start_i,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] sh_stop_i,
  output asha_pkg::asha_cmd_t             cmd_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0] idx_o
);
  import asha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_INIT   = 4'd1;
  localparam logic [3:0] S_SCAN   = 4'd2;
  localparam logic [3:0] S_SDRAIN = 4'd3;
  localparam logic [3:0] S_DECIDE = 4'd4;
  localparam logic [3:0] S_PLAN   = 4'd5;
  localparam logic [3:0] S_SHRD   = 4'd6;
  localparam logic [3:0] S_SHWR   = 4'd7;
  localparam logic [3:0] S_WR1    = 4'd8;
  localparam logic [3:0] S_WR2    = 4'd9;
  localparam logic [3:0] S_COMMIT = 4'd10;
  localparam logic [3:0] S_STAT   = 4'd11;
  localparam logic [3:0] S_TDRAIN = 4'd12;
  localparam logic [3:0] S_LOAD   = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          idx_d        = '0;
          state_d      = sts_i.init_pend ? S_INIT : S_SCAN;
        end
      end
      S_INIT: begin
        cmd_o.wr_init = 1'b1;
        state_d       = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (idx_q == last_idx_i) begin
          state_d = S_SDRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SDRAIN: state_d = S_DECIDE;
      S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = S_PLAN;
      end
      S_PLAN: begin
        if (!sts_i.modify) begin
          idx_d   = '0;
          state_d = S_STAT;
        end else if (sts_i.sh_en) begin
          idx_d   = sh_start_i;
          state_d = S_SHRD;
        end else begin
          state_d = S_WR1;
        end
      end
      S_SHRD: state_d = S_SHWR;
      S_SHWR: begin
        cmd_o.wr_shift = 1'b1;
        if (idx_q == sh_stop_i) begin
          state_d = S_WR1;
        end else begin
          idx_d   = sts_i.sh_up ? idx_q - 1'b1 : idx_q + 1'b1;
          state_d = S_SHRD;
        end
      end
      S_WR1: begin
        cmd_o.wr_e1 = 1'b1;
        state_d     = sts_i.two_wr ? S_WR2 : S_COMMIT;
      end
      S_WR2: begin
        cmd_o.wr_e2 = 1'b1;
        state_d     = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        idx_d        = '0;
        state_d      = S_STAT;
      end
      S_STAT: begin
        cmd_o.stat_rd = 1'b1;
        if (idx_q == last_idx_i) begin
          state_d = S_TDRAIN;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_TDRAIN: state_d = S_LOAD;
      S_LOAD: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign idx_o       = idx_q;
endmodule

// File: rtl/asha_dp.sv
module asha_dp #(
  parameter int unsigned MAX_SEGMENTS = asha_pkg::DefMaxSegments
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  input  logic [1:0]                      op_i,
  input  logic [31:0]                     request_bytes_i,
  input  logic [3:0]                      align_log2_i,
  input  logic [31:0]                     free_address_i,
  input  asha_pkg::asha_cmd_t             cmd_i,
  input  logic [$clog2(MAX_SEGMENTS)-1:0] idx_i,
  output asha_pkg::asha_sts_t             sts_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0] last_idx_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0] sh_start_o,
  output logic [$clog2(MAX_SEGMENTS)-1:0] sh_stop_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      status_code_o,
  output logic [31:0]                     client_address_o,
  output logic [31:0]                     total_free_o,
  output logic [31:0]                     largest_free_o,
  output logic [6:0]                      used_count_o
);
  import asha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned XW = CW + 1;

  // configuration and table bookkeeping
  logic [31:0]   base_q, bytes_q;
  logic [1:0]    policy_q;
  logic          init_q;
  logic [CW-1:0] count_q;

  // request
  logic [1:0]  op_q;
  logic [31:0] size_q, mask_q, faddr_q;

  // table memory
  logic          we;
  logic [AW-1:0] waddr;
  seg_t          wdata, rdata;
  logic          scan_v_q, stat_v_q;
  logic [AW-1:0] ridx_q;

  // scan results
  logic          found_q;
  logic [AW-1:0] pick_q;
  seg_t          pick_ent_q, prev_ent_q, next_ent_q, last_ent_q;

  // status sums
  logic [31:0] total_q, largest_q;
  logic [6:0]  used_q;

  // plan
  logic [1:0]    code_d, code_q;
  logic [31:0]   client_d, client_q;
  logic          mod_d, mod_q, two_d, two_q, shen_d, shen_q, up_d, up_q;
  logic [1:0]    dist_d, dist_q;
  logic [AW-1:0] a1_d, a1_q, a2_d, a2_q, shs_d, shs_q, she_d, she_q;
  seg_t          e1_d, e1_q, e2_d, e2_q;
  logic [CW-1:0] cnt_d, cnt_q;

  logic        out_valid_q;
  logic [1:0]  out_code_q;
  logic [31:0] out_client_q, out_total_q, out_largest_q;
  logic [6:0]  out_used_q;

  asha_ram #(
    .WIDTH ($bits(seg_t)),
    .DEPTH (MAX_SEGMENTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (idx_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      bytes_q  <= '0;
      policy_q <= POL_FIRST;
      init_q   <= 1'b1;
      count_q  <= CW'(1);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_BASE: begin
            base_q  <= cfg_data_i;
            init_q  <= 1'b1;
            count_q <= CW'(1);
          end
          CFG_BYTES: begin
            bytes_q <= cfg_data_i;
            init_q  <= 1'b1;
            count_q <= CW'(1);
          end
          CFG_POLICY: begin
            policy_q <= cfg_data_i[1:0];
            init_q   <= 1'b1;
            count_q  <= CW'(1);
          end
          default: ;
        endcase
      end
      if (cmd_i.wr_init) begin
        init_q <= 1'b0;
      end
      if (cmd_i.commit) begin
        count_q <= cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= op_i;
      size_q  <= request_bytes_i;
      mask_q  <= (32'd1 << align_log2_i) - 32'd1;
      faddr_q <= free_address_i;
    end
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd_i.wr_init) begin
      we          = 1'b1;
      wdata.start = base_q;
      wdata.len   = bytes_q;
    end else if (cmd_i.wr_shift) begin
      we    = 1'b1;
      waddr = up_q ? ridx_q + 1'b1 : ridx_q - AW'(dist_q);
      wdata = rdata;
    end else if (cmd_i.wr_e1) begin
      we    = 1'b1;
      waddr = a1_q;
      wdata = e1_q;
    end else if (cmd_i.wr_e2) begin
      we    = 1'b1;
      waddr = a2_q;
      wdata = e2_q;
    end
  end

  // per-entry fit and match tests
  logic [31:0] rpad;
  logic        rfit, rtake;
  assign rpad = (32'd0 - rdata.start) & mask_q;
  assign rfit = !rdata.used &&
                ({1'b0, size_q} + {1'b0, rpad}) <= {1'b0, rdata.len};

  always_comb begin
    rtake = 1'b0;
    if (op_q == OP_ALLOC) begin
      case (policy_q)
        POL_LAST:    rtake = rfit;
        POL_CLOSEST: rtake = rfit && (!found_q || rdata.len < pick_ent_q.len);
        default:     rtake = rfit && !found_q;
      endcase
    end else if (op_q == OP_FREE) begin
      rtake = !found_q && rdata.used && rdata.client == faddr_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_v_q <= 1'b0;
      stat_v_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      scan_v_q <= cmd_i.scan_rd;
      stat_v_q <= cmd_i.stat_rd;
      if (cmd_i.accept) begin
        found_q <= 1'b0;
      end else if (scan_v_q && rtake) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q <= idx_i;
    if (scan_v_q) begin
      last_ent_q <= rdata;
      if (rtake) begin
        pick_q     <= ridx_q;
        pick_ent_q <= rdata;
        prev_ent_q <= last_ent_q;
      end
      if (found_q && ridx_q == pick_q + 1'b1) begin
        next_ent_q <= rdata;
      end
    end
    if (cmd_i.decide) begin
      total_q   <= '0;
      largest_q <= '0;
      used_q    <= '0;
    end else if (stat_v_q) begin
      if (rdata.used) begin
        used_q <= used_q + 7'd1;
      end else begin
        total_q <= total_q + rdata.len;
        if (rdata.len > largest_q) begin
          largest_q <= rdata.len;
        end
      end
    end
  end

  // plan the table update from the scan result
  logic [31:0]   ps, pl, pad_p, need, off0, addr_l, off_l;
  logic          split, full, mnext, mprev;
  logic [XW-1:0] pick_x, cnt_x, lo_x;

  always_comb begin
    ps     = pick_ent_q.start;
    pl     = pick_ent_q.len;
    pad_p  = (32'd0 - ps) & mask_q;
    need   = size_q + pad_p;
    off0   = pl - size_q;
    addr_l = ps + off0;
    off_l  = off0 - (addr_l & mask_q);
    split  = (policy_q == POL_LAST) ? (off_l != 32'd0) : (pl != need);
    full   = count_q >= CW'(MAX_SEGMENTS);
    pick_x = XW'(pick_q);
    cnt_x  = XW'(count_q);
    mnext  = (pick_x + XW'(1) < cnt_x) && !next_ent_q.used;
    mprev  = (pick_q != '0) && !prev_ent_q.used;
    lo_x   = '0;

    code_d   = ST_OK;
    client_d = '0;
    mod_d    = 1'b0;
    two_d    = 1'b0;
    shen_d   = 1'b0;
    up_d     = 1'b0;
    dist_d   = 2'd1;
    a1_d     = pick_q;
    a2_d     = pick_q + 1'b1;
    shs_d    = '0;
    she_d    = '0;
    e1_d     = '0;
    e2_d     = '0;
    cnt_d    = count_q;

    case (op_q)
      OP_ALLOC: begin
        if (size_q == 32'd0) begin
          code_d = ST_ZERO;
        end else if (!found_q || (split && full)) begin
          code_d = ST_NOFIT;
        end else begin
          mod_d  = 1'b1;
          two_d  = split;
          up_d   = 1'b1;
          shen_d = split && (pick_x + XW'(2) <= cnt_x);
          shs_d  = AW'(count_q - CW'(1));
          she_d  = pick_q + 1'b1;
          if (split) begin
            cnt_d = count_q + CW'(1);
          end
          if (policy_q == POL_LAST) begin
            if (split) begin
              e1_d.start  = ps;
              e1_d.len    = off_l;
              e2_d.start  = ps + off_l;
              e2_d.len    = pl - off_l;
              e2_d.used   = 1'b1;
              e2_d.client = ps + off_l;
              client_d    = ps + off_l;
            end else begin
              e1_d.start  = ps;
              e1_d.len    = pl;
              e1_d.used   = 1'b1;
              e1_d.client = ps;
              client_d    = ps;
            end
          end else begin
            e1_d.start  = ps;
            e1_d.len    = need;
            e1_d.used   = 1'b1;
            e1_d.client = ps + pad_p;
            e2_d.start  = ps + need;
            e2_d.len    = pl - need;
            client_d    = ps + pad_p;
          end
        end
      end
      OP_FREE: begin
        if (!found_q) begin
          code_d = ST_NOTFOUND;
        end else begin
          mod_d = 1'b1;
          if (mnext && mprev) begin
            a1_d     = pick_q - 1'b1;
            e1_d.start = prev_ent_q.start;
            e1_d.len = prev_ent_q.len + pl + next_ent_q.len;
            lo_x     = pick_x + XW'(2);
            dist_d   = 2'd2;
            cnt_d    = count_q - CW'(2);
          end else if (mnext) begin
            e1_d.start = ps;
            e1_d.len = pl + next_ent_q.len;
            lo_x     = pick_x + XW'(2);
            cnt_d    = count_q - CW'(1);
          end else if (mprev) begin
            a1_d     = pick_q - 1'b1;
            e1_d.start = prev_ent_q.start;
            e1_d.len = prev_ent_q.len + pl;
            lo_x     = pick_x + XW'(1);
            cnt_d    = count_q - CW'(1);
          end else begin
            e1_d.start = ps;
            e1_d.len = pl;
          end
          shen_d = (mnext || mprev) && (lo_x < cnt_x);
          shs_d  = AW'(lo_x);
          she_d  = AW'(count_q - CW'(1));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= 1'b0;
      two_q  <= 1'b0;
      shen_q <= 1'b0;
      up_q   <= 1'b0;
    end else if (cmd_i.decide) begin
      mod_q  <= mod_d;
      two_q  <= two_d;
      shen_q <= shen_d;
      up_q   <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      code_q   <= code_d;
      client_q <= client_d;
      dist_q   <= dist_d;
      a1_q     <= a1_d;
      a2_q     <= a2_d;
      shs_q    <= shs_d;
      she_q    <= she_d;
      e1_q     <= e1_d;
      e2_q     <= e2_d;
      cnt_q    <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_code_q    <= code_q;
      out_client_q  <= client_q;
      out_total_q   <= total_q;
      out_largest_q <= largest_q;
      out_used_q    <= used_q;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.init_pend = init_q;
    sts_o.modify    = mod_q;
    sts_o.sh_en     = shen_q;
    sts_o.sh_up     = up_q;
    sts_o.two_wr    = two_q;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign last_idx_o       = AW'(count_q - CW'(1));
  assign sh_start_o       = shs_q;
  assign sh_stop_o        = she_q;
  assign out_valid_o      = out_valid_q;
  assign status_code_o    = out_code_q;
  assign client_address_o = out_client_q;
  assign total_free_o     = out_total_q;
  assign largest_free_o   = out_largest_q;
  assign used_count_o     = out_used_q;
endmodule

// File: rtl/aligned_segment_heap_allocator_unit.sv
// Channel   Dir  Beat payload
// --------  ---  ---------------------------------------------------------------
// req       in   op, request_bytes, align_log2, free_address
// rsp       out  status_code, client_address, total_free, largest_free, used_count
// cfg       in   cfg_we_i / cfg_idx_i / cfg_data_i, one register write per cycle
//
// One request at a time. A request walks the segment table, plans the update,
// shifts the entries that open or close a slot, writes back the changed entries
// and commits them, then walks the table again for the status sums; a request
// that leaves the table alone skips the shift, the write back and the commit.
// The single read port of the segment memory serialises these steps.
// Reset and every configuration write mark the table as one free segment; the
// next request writes that entry before its walk. A stalled result sits
// in the output register while the next request is taken.
module aligned_segment_heap_allocator_unit #(
  parameter int unsigned MAX_SEGMENTS = asha_pkg::DefMaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  asha_req_if.sink    req,
  asha_rsp_if.source  rsp,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import asha_pkg::*;

  localparam int unsigned AW = $clog2(MAX_SEGMENTS);

  asha_cmd_t     cmd;
  asha_sts_t     sts;
  logic [AW-1:0] idx, last_idx, sh_start, sh_stop;

  // sequencer: walk, plan, shift, write back, walk for status
  asha_ctrl #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req.valid),
    .req_ready_o (req.ready),
    .sts_i       (sts),
    .last_idx_i  (last_idx),
    .sh_start_i  (sh_start),
    .sh_stop_i   (sh_stop),
    .cmd_o       (cmd),
    .idx_o       (idx)
  );

  // segment table, fit search, merge logic and result register
  asha_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .op_i             (req.op),
    .request_bytes_i  (req.request_bytes),
    .align_log2_i     (req.align_log2),
    .free_address_i   (req.free_address),
    .cmd_i            (cmd),
    .idx_i            (idx),
    .sts_o            (sts),
    .last_idx_o       (last_idx),
    .sh_start_o       (sh_start),
    .sh_stop_o        (sh_stop),
    .out_ready_i      (rsp.ready),
    .out_valid_o      (rsp.valid),
    .status_code_o    (rsp.status_code),
    .client_address_o (rsp.client_address),
    .total_free_o     (rsp.total_free),
    .largest_free_o   (rsp.largest_free),
    .used_count_o     (rsp.used_count)
  );
endmodule
